FILE: sv/aia_pkg.sv
// ----------------------------------------------------------------------------
// aia_pkg: shared types and constants of the aging index allocator
// Field widths, head cell codes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package aia_pkg;

   localparam int MODE_W           = 2;
   localparam int IDX_W            = 10;
   localparam int DEFAULT_CAPACITY = 1024;

   // head cells of the two chains; index i lives in cell i + CELL_SHIFT
   localparam int AGE_CHAIN_HEAD   = 0;
   localparam int FREE_CHAIN_HEAD  = 1;
   localparam int CELL_SHIFT       = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_REJUV = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_LINK,
      ST_APPEND,
      ST_TAIL,
      ST_PUSH,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: sv/aia_if.sv
// ----------------------------------------------------------------------------
// aia_if: request and response channels of the aging index allocator
// Valid/ready channels; a word moves on an edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface aia_req_if;
   logic                      valid;
   logic                      ready;
   logic [aia_pkg::MODE_W-1:0] mode;
   logic [aia_pkg::IDX_W-1:0]  index;

   modport source (output valid, output mode, output index, input ready);
   modport sink   (input valid, input mode, input index, output ready);
endinterface

interface aia_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      success;
   logic [aia_pkg::IDX_W-1:0]  given_index;
   logic                      is_allocated;
   logic                      has_next;
   logic [aia_pkg::IDX_W-1:0]  next_index;
   logic                      oldest_valid;
   logic [aia_pkg::IDX_W-1:0]  oldest_index;

   modport source (output valid, output success, output given_index,
                   output is_allocated, output has_next, output next_index,
                   output oldest_valid, output oldest_index, input ready);
   modport sink   (input valid, input success, input given_index,
                   input is_allocated, input has_next, input next_index,
                   input oldest_valid, input oldest_index, output ready);
endinterface

`default_nettype wire

FILE: sv/aia_link_ram.sv
// ----------------------------------------------------------------------------
// aia_link_ram: link memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aia_link_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: sv/aging_index_allocator.sv
// ----------------------------------------------------------------------------
// aging_index_allocator: index allocator with an age-ordered chain
// Free chain (LIFO) and age chain (oldest first) kept in two link memories.
// ----------------------------------------------------------------------------
// Hands out indexes 0 .. CAPACITY-1. Mode 0 allocates the top of the free
// chain and makes it the newest, mode 1 frees an allocated index, mode 2 moves
// an allocated index to the newest end, mode 3 reports whether an index is
// allocated and which index follows it in age order. Every response also
// carries the oldest allocated index. One request is worked on at a time: it
// reads the two links of its cell; free and rejuvenate unlink the cell,
// allocate and rejuvenate append it at the newest end, free pushes it onto
// the free chain and query goes to the response. A free or rejuvenate of an
// index that is not allocated, or a rejuvenate of the only allocated index,
// stops after the read; an allocate on a full table or an out-of-range
// request goes straight to the response, and any request may wait for the
// response register to drain. The steps follow from the single write port
// of each link memory and its registered read data. After reset the block
// writes the initial free chain before it accepts the first request.
`default_nettype none

module aging_index_allocator #(
   parameter int CAPACITY = aia_pkg::DEFAULT_CAPACITY
) (
   input  wire logic clock,
   input  wire logic reset,
   aia_req_if.sink   req_bus,
   aia_rsp_if.source rsp_bus
);

   import aia_pkg::*;

   localparam int CELL_W = $clog2(CAPACITY + 2);
   localparam int ADDR_W = $clog2(CAPACITY);

   localparam logic [CELL_W-1:0] AGE_HEAD   = CELL_W'(AGE_CHAIN_HEAD);
   localparam logic [CELL_W-1:0] FREE_HEAD  = CELL_W'(FREE_CHAIN_HEAD);
   localparam logic [CELL_W-1:0] SHIFT_C    = CELL_W'(CELL_SHIFT);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CAPACITY - 1);

   function automatic logic [ADDR_W-1:0] to_addr(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] rel;
      rel = c - SHIFT_C;
      return ADDR_W'(rel);
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [CELL_W-1:0] c);
      logic [CELL_W-1:0] rel;
      rel = c - SHIFT_C;
      return IDX_W'(rel);
   endfunction

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] init_cnt_ff, init_cnt_in;
   mode_type          mode_ff, mode_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [CELL_W-1:0] tail_ff, tail_in;
   logic [CELL_W-1:0] oldest_ff, oldest_in;
   logic [CELL_W-1:0] newest_ff, newest_in;
   logic [CELL_W-1:0] free_top_ff, free_top_in;

   logic              success_ff, success_in;
   logic [IDX_W-1:0]  given_ff, given_in;
   logic              is_alloc_ff, is_alloc_in;
   logic              has_next_ff, has_next_in;
   logic [IDX_W-1:0]  next_ff, next_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_success_ff, rsp_success_in;
   logic [IDX_W-1:0]  rsp_given_ff, rsp_given_in;
   logic              rsp_is_alloc_ff, rsp_is_alloc_in;
   logic              rsp_has_next_ff, rsp_has_next_in;
   logic [IDX_W-1:0]  rsp_next_ff, rsp_next_in;
   logic              rsp_oldest_valid_ff, rsp_oldest_valid_in;
   logic [IDX_W-1:0]  rsp_oldest_ff, rsp_oldest_in;

   logic              fwd_we, bwd_we, link_re;
   logic [ADDR_W-1:0] fwd_waddr, bwd_waddr, link_raddr;
   logic [CELL_W-1:0] fwd_wdata, bwd_wdata;
   logic [CELL_W-1:0] fwd_q, bwd_q;

   logic              req_fire;
   logic              in_range;
   logic              cell_alloc;
   logic              rsp_free;
   logic              init_last;

   aia_link_ram #(.DEPTH(CAPACITY), .WIDTH(CELL_W)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_we),
      .wr_addr (fwd_waddr),
      .wr_data (fwd_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (fwd_q)
   );

   aia_link_ram #(.DEPTH(CAPACITY), .WIDTH(CELL_W)) u_bwd_ram (
      .clock   (clock),
      .wr_en   (bwd_we),
      .wr_addr (bwd_waddr),
      .wr_data (bwd_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (bwd_q)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);
   assign in_range      = (32'(req_bus.index) < 32'(CAPACITY));
   // free cells hold the same link twice; the sole allocated cell points home
   assign cell_alloc    = (fwd_q != bwd_q) || (fwd_q == AGE_HEAD);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign init_last     = (init_cnt_ff == LAST_ADDR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (mode_type'(req_bus.mode) == MODE_ALLOC) begin
                  state_in = (free_top_ff == FREE_HEAD) ? ST_DONE : ST_READ;
               end else begin
                  state_in = in_range ? ST_READ : ST_DONE;
               end
            end
         end
         ST_READ: state_in = ST_LINK;
         ST_LINK: begin
            unique case (mode_ff)
               MODE_ALLOC: state_in = ST_APPEND;
               MODE_FREE:  state_in = cell_alloc ? ST_PUSH : ST_DONE;
               MODE_REJUV: state_in = (cell_alloc && fwd_q != bwd_q) ? ST_APPEND : ST_DONE;
               MODE_QUERY: state_in = ST_DONE;
            endcase
         end
         ST_APPEND: state_in = ST_TAIL;
         ST_TAIL:   state_in = ST_DONE;
         ST_PUSH:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      init_cnt_in  = init_cnt_ff;
      mode_in      = mode_ff;
      cell_in      = cell_ff;
      tail_in      = tail_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      free_top_in  = free_top_ff;
      success_in   = success_ff;
      given_in     = given_ff;
      is_alloc_in  = is_alloc_ff;
      has_next_in  = has_next_ff;
      next_in      = next_ff;

      rsp_valid_in        = rsp_valid_ff && !rsp_bus.ready;
      rsp_success_in      = rsp_success_ff;
      rsp_given_in        = rsp_given_ff;
      rsp_is_alloc_in     = rsp_is_alloc_ff;
      rsp_has_next_in     = rsp_has_next_ff;
      rsp_next_in         = rsp_next_ff;
      rsp_oldest_valid_in = rsp_oldest_valid_ff;
      rsp_oldest_in       = rsp_oldest_ff;

      fwd_we     = 1'b0;
      bwd_we     = 1'b0;
      fwd_waddr  = to_addr(cell_ff);
      bwd_waddr  = to_addr(cell_ff);
      fwd_wdata  = AGE_HEAD;
      bwd_wdata  = AGE_HEAD;
      link_re    = 1'b0;
      link_raddr = to_addr(cell_ff);

      unique case (state_ff)
         ST_INIT: begin
            // ascending free chain, last cell closes back to the free head
            fwd_we      = 1'b1;
            bwd_we      = 1'b1;
            fwd_waddr   = init_cnt_ff;
            bwd_waddr   = init_cnt_ff;
            fwd_wdata   = init_last ? FREE_HEAD : CELL_W'(init_cnt_ff) + SHIFT_C + CELL_W'(1);
            bwd_wdata   = fwd_wdata;
            init_cnt_in = init_cnt_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               mode_in     = mode_type'(req_bus.mode);
               success_in  = 1'b0;
               given_in    = '0;
               is_alloc_in = 1'b0;
               has_next_in = 1'b0;
               next_in     = '0;
               if (mode_type'(req_bus.mode) == MODE_ALLOC) begin
                  cell_in = free_top_ff;
               end else begin
                  cell_in = CELL_W'(req_bus.index) + SHIFT_C;
               end
            end
         end
         ST_READ: begin
            link_re = 1'b1;
         end
         ST_LINK: begin
            unique case (mode_ff)
               MODE_ALLOC: begin
                  free_top_in = fwd_q;
               end
               MODE_FREE, MODE_REJUV: begin
                  if (cell_alloc && (mode_ff == MODE_FREE || fwd_q != bwd_q)) begin
                     // unlink: neighbors point past this cell
                     if (bwd_q == AGE_HEAD) begin
                        oldest_in = fwd_q;
                     end else begin
                        fwd_we    = 1'b1;
                        fwd_waddr = to_addr(bwd_q);
                        fwd_wdata = fwd_q;
                     end
                     if (fwd_q == AGE_HEAD) begin
                        newest_in = bwd_q;
                     end else begin
                        bwd_we    = 1'b1;
                        bwd_waddr = to_addr(fwd_q);
                        bwd_wdata = bwd_q;
                     end
                  end
                  if (mode_ff == MODE_REJUV && cell_alloc) begin
                     success_in = 1'b1;
                  end
               end
               MODE_QUERY: begin
                  if (cell_alloc) begin
                     success_in  = 1'b1;
                     is_alloc_in = 1'b1;
                     if (fwd_q >= SHIFT_C) begin
                        has_next_in = 1'b1;
                        next_in     = to_idx(fwd_q);
                     end
                  end
               end
            endcase
         end
         ST_APPEND: begin
            fwd_we    = 1'b1;
            bwd_we    = 1'b1;
            fwd_wdata = AGE_HEAD;
            bwd_wdata = newest_ff;
            tail_in   = newest_ff;
            newest_in = cell_ff;
         end
         ST_TAIL: begin
            if (tail_ff == AGE_HEAD) begin
               oldest_in = cell_ff;
            end else begin
               fwd_we    = 1'b1;
               fwd_waddr = to_addr(tail_ff);
               fwd_wdata = cell_ff;
            end
            success_in = 1'b1;
            if (mode_ff == MODE_ALLOC) begin
               given_in = to_idx(cell_ff);
            end
         end
         ST_PUSH: begin
            fwd_we      = 1'b1;
            bwd_we      = 1'b1;
            fwd_wdata   = free_top_ff;
            bwd_wdata   = free_top_ff;
            free_top_in = cell_ff;
            success_in  = 1'b1;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_success_in      = success_ff;
               rsp_given_in        = given_ff;
               rsp_is_alloc_in     = is_alloc_ff;
               rsp_has_next_in     = has_next_ff;
               rsp_next_in         = next_ff;
               rsp_oldest_valid_in = (oldest_ff >= SHIFT_C);
               rsp_oldest_in       = (oldest_ff >= SHIFT_C) ? to_idx(oldest_ff) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         oldest_ff    <= AGE_HEAD;
         newest_ff    <= AGE_HEAD;
         free_top_ff  <= SHIFT_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         free_top_ff  <= free_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff             <= mode_in;
      cell_ff             <= cell_in;
      tail_ff             <= tail_in;
      success_ff          <= success_in;
      given_ff            <= given_in;
      is_alloc_ff         <= is_alloc_in;
      has_next_ff         <= has_next_in;
      next_ff             <= next_in;
      rsp_success_ff      <= rsp_success_in;
      rsp_given_ff        <= rsp_given_in;
      rsp_is_alloc_ff     <= rsp_is_alloc_in;
      rsp_has_next_ff     <= rsp_has_next_in;
      rsp_next_ff         <= rsp_next_in;
      rsp_oldest_valid_ff <= rsp_oldest_valid_in;
      rsp_oldest_ff       <= rsp_oldest_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.success      = rsp_success_ff;
   assign rsp_bus.given_index  = rsp_given_ff;
   assign rsp_bus.is_allocated = rsp_is_alloc_ff;
   assign rsp_bus.has_next     = rsp_has_next_ff;
   assign rsp_bus.next_index   = rsp_next_ff;
   assign rsp_bus.oldest_valid = rsp_oldest_valid_ff;
   assign rsp_bus.oldest_index = rsp_oldest_ff;

endmodule

`default_nettype wire
